// File: src/y86_instruction_stream_decoder_assert.svh
// Assertion macros shared by the decoder's checker.
`ifndef Y86_INSTRUCTION_STREAM_DECODER_ASSERT_SVH
`define Y86_INSTRUCTION_STREAM_DECODER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define YSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define YSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ysd_pkg.sv
// Types, constants and the opcode classifier of the Y86 stream decoder.
package ysd_pkg;

  localparam int PROGRAM_BYTES = 4096;
  localparam int ADDR_W        = $clog2(PROGRAM_BYTES);
  localparam int START_W       = 12;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] OP_HALT   = 8'h00;
  localparam logic [7:0] OP_NOP    = 8'h10;
  localparam logic [7:0] OP_RRMOVL = 8'h20;
  localparam logic [7:0] OP_CMOVG  = 8'h26;
  localparam logic [7:0] OP_IRMOVL = 8'h30;
  localparam logic [7:0] OP_RMMOVL = 8'h40;
  localparam logic [7:0] OP_MRMOVL = 8'h50;
  localparam logic [7:0] OP_ADDL   = 8'h60;
  localparam logic [7:0] OP_XORL   = 8'h63;
  localparam logic [7:0] OP_JMP    = 8'h70;
  localparam logic [7:0] OP_JG     = 8'h76;
  localparam logic [7:0] OP_CALL   = 8'h80;
  localparam logic [7:0] OP_RET    = 8'h90;
  localparam logic [7:0] OP_PUSHL  = 8'hA0;
  localparam logic [7:0] OP_POPL   = 8'hB0;

  typedef enum logic [2:0] {
    FORM_NONE,
    FORM_RR,
    FORM_RA,
    FORM_RB_IMM,
    FORM_RR_IMM,
    FORM_IMM
  } ysd_form_t;

  typedef struct packed {
    logic [2:0] len;   // 0 for an unknown opcode
    ysd_form_t  form;
  } ysd_class_t;

  // One collected instruction, as handed from front to back.
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [7:0]         opcode;
    logic [7:0]         reg_byte;
    logic [31:0]        imm;
    logic               truncated;
  } ysd_entry_t;

  typedef struct packed {
    logic       valid;
    ysd_entry_t entry;
  } ysd_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ysd_qstat_t;

  function automatic ysd_class_t classify(input logic [7:0] op);
    ysd_class_t c;
    c.len  = 3'd0;
    c.form = FORM_NONE;
    case (op) inside
      OP_HALT, OP_NOP, OP_RET: begin
        c.len = 3'd1;
      end
      [OP_RRMOVL:OP_CMOVG], [OP_ADDL:OP_XORL]: begin
        c.len  = 3'd2;
        c.form = FORM_RR;
      end
      OP_PUSHL, OP_POPL: begin
        c.len  = 3'd2;
        c.form = FORM_RA;
      end
      OP_IRMOVL: begin
        c.len  = 3'd6;
        c.form = FORM_RB_IMM;
      end
      OP_RMMOVL, OP_MRMOVL: begin
        c.len  = 3'd6;
        c.form = FORM_RR_IMM;
      end
      [OP_JMP:OP_JG], OP_CALL: begin
        c.len  = 3'd5;
        c.form = FORM_IMM;
      end
      default: begin
        c.len  = 3'd0;
        c.form = FORM_NONE;
      end
    endcase
    return c;
  endfunction

endpackage

// File: src/y86_instruction_stream_decoder.sv
// Top level of the Y86 instruction stream decoder.
// Takes one program byte per beat and emits one beat per instruction on the
// byte that completes it (or on the last program byte, flagged truncated).
// The front end decodes each byte combinationally and registers the instruction
// state it updates, so a byte is accepted each cycle while the two-entry queue
// has room. A result is written into the queue when its last byte is accepted, and
// is registered into the output once the output is free. Unknown opcode bytes are dropped.
module y86_instruction_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_program
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // start_address[11:0], opcode[19:12],
                                 // operand_form[22:20], reg_a[26:23], reg_b[30:27],
                                 // immediate[62:31], length[65:63], zero fill
  output logic        m_tuser    // truncated
);
  import ysd_pkg::*;

  ysd_push_t  push;
  ysd_qstat_t qstat;
  ysd_entry_t head;
  logic       pop;

  ysd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .qstat    (qstat),
    .push     (push)
  );

  ysd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (qstat)
  );

  ysd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: src/ysd_queue.sv
// Short register queue between the decoder's front and back.
module ysd_queue (
  input  logic                clk,
  input  logic                rst,
  input  ysd_pkg::ysd_push_t  push,
  input  logic                pop,
  output ysd_pkg::ysd_entry_t head,
  output ysd_pkg::ysd_qstat_t stat
);
  import ysd_pkg::*;

  ysd_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign do_push    = push.valid && (count != QCNT_W'(QUEUE_DEPTH));
  assign do_pop     = pop && (count != '0);
  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

// File: src/ysd_front.sv
// Front end: takes program bytes, tracks instruction boundaries, collects fields.
module ysd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tlast,   // end_of_program
  input  ysd_pkg::ysd_qstat_t qstat,
  output ysd_pkg::ysd_push_t  push
);
  import ysd_pkg::*;

  logic [2:0]         byte_position;
  logic [7:0]         held_opcode;
  logic [7:0]         held_register_byte;
  logic [31:0]        immediate_accumulator;
  logic [ADDR_W-1:0]  byte_address;
  logic [ADDR_W-1:0]  instruction_start;

  logic [2:0]         byte_position_next;
  logic [7:0]         held_opcode_next;
  logic [7:0]         held_register_byte_next;
  logic [31:0]        immediate_accumulator_next;
  logic [ADDR_W-1:0]  instruction_start_next;

  ysd_class_t         cls_held;
  ysd_class_t         cls_byte;
  ysd_class_t         cls_next;
  logic [2:0]         imm_idx;
  logic               accept;
  logic               emit;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    held_opcode_next           = held_opcode;
    held_register_byte_next    = held_register_byte;
    immediate_accumulator_next = immediate_accumulator;
    instruction_start_next     = instruction_start;
    byte_position_next         = byte_position;
    cls_held                   = classify(held_opcode);
    cls_byte                   = classify(s_tdata);
    imm_idx                    = '0;
    if (byte_position == 3'd0) begin
      // unknown opcode bytes leave everything as is
      if (cls_byte.len != 3'd0) begin
        held_opcode_next           = s_tdata;
        held_register_byte_next    = '0;
        immediate_accumulator_next = '0;
        instruction_start_next     = byte_address;
        byte_position_next         = 3'd1;
      end
    end else begin
      if (cls_held.form != FORM_IMM && byte_position == 3'd1) begin
        held_register_byte_next = s_tdata;
      end else begin
        imm_idx = byte_position - ((cls_held.form != FORM_IMM) ? 3'd2 : 3'd1);
        immediate_accumulator_next = immediate_accumulator
                                     | ({24'b0, s_tdata} << {imm_idx[1:0], 3'b000});
      end
      byte_position_next = byte_position + 3'd1;
    end
    cls_next = classify(held_opcode_next);
    emit = (byte_position_next != 3'd0)
           && ((byte_position_next >= cls_next.len) || s_tlast);
  end

  always_comb begin
    push.valid           = accept && emit;
    push.entry.start     = START_W'(instruction_start_next);
    push.entry.opcode    = held_opcode_next;
    push.entry.reg_byte  = held_register_byte_next;
    push.entry.imm       = immediate_accumulator_next;
    push.entry.truncated = (byte_position_next < cls_next.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      byte_address  <= '0;
    end else if (accept) begin
      byte_position <= (emit || s_tlast) ? 3'd0 : byte_position_next;
      if (s_tlast || byte_address == ADDR_W'(PROGRAM_BYTES - 1)) begin
        byte_address <= '0;
      end else begin
        byte_address <= byte_address + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_opcode           <= held_opcode_next;
      held_register_byte    <= held_register_byte_next;
      immediate_accumulator <= immediate_accumulator_next;
      instruction_start     <= instruction_start_next;
    end
  end

endmodule

// File: src/ysd_back.sv
// Back end: formats a collected instruction into the output register.
module ysd_back (
  input  logic                clk,
  input  logic                rst,
  input  ysd_pkg::ysd_entry_t head,
  input  ysd_pkg::ysd_qstat_t qstat,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [71:0]         m_tdata,   // start_address, opcode, operand_form, reg_a,
                                         // reg_b, immediate, length, zero fill
  output logic                m_tuser    // truncated
);
  import ysd_pkg::*;

  ysd_class_t  cls;
  logic [3:0]  reg_a;
  logic [3:0]  reg_b;
  logic [31:0] imm;

  assign pop = !qstat.empty && (!m_tvalid || m_tready);

  always_comb begin
    cls   = classify(head.opcode);
    reg_a = (cls.form == FORM_RR || cls.form == FORM_RA || cls.form == FORM_RR_IMM)
            ? head.reg_byte[7:4] : 4'd0;
    reg_b = (cls.form == FORM_RR || cls.form == FORM_RB_IMM || cls.form == FORM_RR_IMM)
            ? head.reg_byte[3:0] : 4'd0;
    imm   = (cls.form == FORM_RB_IMM || cls.form == FORM_RR_IMM || cls.form == FORM_IMM)
            ? head.imm : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {6'b0, cls.len, imm, reg_b, reg_a, cls.form, head.opcode, head.start};
      m_tuser <= head.truncated;
    end
  end

endmodule

// File: src/y86_instruction_stream_decoder_checker.sv
// Port-level checker for the decoder, bound to the top level.
`include "y86_instruction_stream_decoder_assert.svh"

module y86_instruction_stream_decoder_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser
);
  import ysd_pkg::*;

  logic [2:0]  form;
  logic [2:0]  len;
  logic [7:0]  regs;
  logic [72:0] beat;
  logic        stall;
  logic        no_regs;
  logic        len_form_ok;

  assign form    = m_tdata[22:20];
  assign len     = m_tdata[65:63];
  assign regs    = m_tdata[30:23];
  assign beat    = {m_tuser, m_tdata};
  assign stall   = m_tvalid && !m_tready;
  assign no_regs = (form == FORM_NONE) || (form == FORM_IMM);

  assign len_form_ok = (form == FORM_NONE)                         ? (len == 3'd1) :
                       (form == FORM_RR || form == FORM_RA)         ? (len == 3'd2) :
                       (form == FORM_IMM)                           ? (len == 3'd5) :
                       (form == FORM_RB_IMM || form == FORM_RR_IMM) ? (len == 3'd6) :
                       1'b0;

  `YSD_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(beat), "stalled beat changed")
  `YSD_ASSERT_NOW(a_len_form, m_tvalid, len_form_ok, "length and operand form disagree")
  `YSD_ASSERT_NOW(a_trunc_len, m_tvalid && m_tuser, len != 3'd1, "one-byte op truncated")
  `YSD_ASSERT_NOW(a_imm_only_regs, m_tvalid && no_regs, regs == 8'd0, "stray register nibbles")

endmodule

bind y86_instruction_stream_decoder y86_instruction_stream_decoder_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
